@@ hdl/dpjs_pkg.sv @@
package dpjs_pkg;

	// Port field widths
	localparam int OP_W       = 2;
	localparam int PRIO_IN_W  = 16;
	localparam int DEPS_W     = 32;
	localparam int TGT_W      = 5;
	localparam int STATUS_W   = 2;
	localparam int IDX_OUT_W  = 5;
	localparam int CNT_OUT_W  = 6;

	// Opcodes
	localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
	localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_READY = 2'd2;

	// Job states as stored in the state memory
	localparam int JST_W = 2;
	localparam logic [JST_W-1:0] JST_WAIT = 2'd0;
	localparam logic [JST_W-1:0] JST_RUN  = 2'd1;
	localparam logic [JST_W-1:0] JST_DONE = 2'd2;
	localparam logic [JST_W-1:0] JST_FAIL = 2'd3;

	typedef logic [JST_W-1:0] job_state_t;

endpackage

@@ hdl/dpjs_ram.sv @@
module dpjs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/dependency_priority_job_scheduler_unit.sv @@
// Dependency-aware priority job scheduler. Jobs fill a table from slot 0;
// each slot holds a state (waiting, running, done, failed) in one RAM and the
// priority and dependency mask in a second RAM, both with a registered read.
// A done mask and the fill and pending counts sit in flip-flops, so a clear
// is immediate and no clearing pass runs after reset. One transaction is
// worked at a time. Add, clear, a rejected complete and a dispatch on an
// empty table pass from the start state straight to the emit state. An
// accepted complete passes through the complete state, since it reads the old
// state to keep the pending count. Any other dispatch reads every filled slot
// once through the RAM read port, keeping the best eligible job, then writes
// its state to running. A new input is taken while a finished result still
// waits at the output register. Dependency bits that name a slot beyond the
// table or not yet filled never count as done.
module dependency_priority_job_scheduler_unit
	import dpjs_pkg::*;
#(
	parameter int TABLE_DEPTH    = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [OP_W-1:0]             opcode,
	input  logic signed [PRIO_IN_W-1:0] job_priority,
	input  logic [DEPS_W-1:0]           dependency_bits,
	input  logic [TGT_W-1:0]            target_index,
	input  logic                        succeeded,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [STATUS_W-1:0]         status,
	output logic [IDX_OUT_W-1:0]        result_index,
	output logic [CNT_OUT_W-1:0]        pending_count
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PAY_W = PRIORITY_WIDTH + DEPS_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_CMPL  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DISP  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;

	// Latched transaction
	logic [OP_W-1:0]                  op_q;
	logic signed [PRIORITY_WIDTH-1:0] prio_q;
	logic [DEPS_W-1:0]                deps_q;
	logic [TGT_W-1:0]                 tgt_q;
	logic                             succ_q;

	// Table bookkeeping
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       pending_q;
	logic [TABLE_DEPTH-1:0] done_q;

	// Scan state
	logic [IDX_W-1:0]                 ptr_q;
	logic                             found_q;
	logic [IDX_W-1:0]                 best_idx_q;
	logic signed [PRIORITY_WIDTH-1:0] best_prio_q;

	// Result waiting for the output register
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_idx_q;

	// RAM ports
	logic                             st_we;
	logic [IDX_W-1:0]                 st_waddr;
	job_state_t                       st_wdata;
	job_state_t                       st_rdata;
	logic                             pay_we;
	logic [IDX_W-1:0]                 raddr;
	logic [PAY_W-1:0]                 pay_rdata;
	logic signed [PRIORITY_WIDTH-1:0] rd_prio;
	logic [DEPS_W-1:0]                rd_deps;

	logic                             full;
	logic                             tgt_bad;
	logic                             scan_last;
	logic                             eligible;
	logic [DEPS_W-1:0]                done_wide;
	logic                             out_free;

	assign rd_prio   = pay_rdata[PAY_W-1 -: PRIORITY_WIDTH];
	assign rd_deps   = pay_rdata[DEPS_W-1:0];
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign tgt_bad   = (32'(tgt_q) >= 32'(count_q));
	assign scan_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	// Done mask seen as a dependency word; slots beyond the table never done
	for (genvar i = 0; i < DEPS_W; i++) begin : g_done
		if (i < TABLE_DEPTH) begin : g_in
			assign done_wide[i] = done_q[i];
		end else begin : g_out
			assign done_wide[i] = 1'b0;
		end
	end

	assign eligible = (st_rdata == JST_WAIT) && ((rd_deps & done_wide) == rd_deps);

	// Memory address and write control
	always_comb begin
		st_we    = 1'b0;
		st_waddr = IDX_W'(count_q);
		st_wdata = JST_WAIT;
		pay_we   = 1'b0;
		raddr    = ptr_q + IDX_W'(1);
		case (state_q)
			S_START: begin
				if (op_q == OP_ADD && !full) begin
					st_we  = 1'b1;
					pay_we = 1'b1;
				end
				if (op_q == OP_COMPLETE) begin
					raddr = IDX_W'(tgt_q);
				end else begin
					raddr = '0;
				end
			end
			S_CMPL: begin
				st_we    = 1'b1;
				st_waddr = IDX_W'(tgt_q);
				st_wdata = succ_q ? JST_DONE : JST_FAIL;
			end
			S_DISP: begin
				st_we    = found_q;
				st_waddr = best_idx_q;
				st_wdata = JST_RUN;
			end
			default: begin
			end
		endcase
	end

	dpjs_ram #(
		.WIDTH (JST_W),
		.DEPTH (TABLE_DEPTH)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (raddr),
		.rdata (st_rdata)
	);

	dpjs_ram #(
		.WIDTH (PAY_W),
		.DEPTH (TABLE_DEPTH)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (IDX_W'(count_q)),
		.wdata ({prio_q, deps_q}),
		.raddr (raddr),
		.rdata (pay_rdata)
	);

	// Input latch
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q   <= opcode;
			prio_q <= PRIORITY_WIDTH'(job_priority);
			deps_q <= dependency_bits;
			tgt_q  <= target_index;
			succ_q <= succeeded;
		end
	end

	// Sequencer and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pending_q    <= '0;
			done_q       <= '0;
			ptr_q        <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_prio_q  <= '0;
			res_status_q <= STATUS_OK;
			res_idx_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					res_status_q <= STATUS_OK;
					res_idx_q    <= '0;
					ptr_q        <= '0;
					found_q      <= 1'b0;
					state_q      <= S_EMIT;
					case (op_q)
						OP_ADD: begin
							if (full) begin
								res_status_q <= STATUS_REJECTED;
							end else begin
								res_idx_q                <= IDX_W'(count_q);
								done_q[IDX_W'(count_q)]  <= 1'b0;
								count_q                  <= count_q + CNT_W'(1);
								pending_q                <= pending_q + CNT_W'(1);
							end
						end
						OP_DISPATCH: begin
							if (count_q == '0) begin
								res_status_q <= STATUS_NO_READY;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_COMPLETE: begin
							if (tgt_bad) begin
								res_status_q <= STATUS_REJECTED;
							end else begin
								state_q <= S_CMPL;
							end
						end
						default: begin
							count_q   <= '0;
							pending_q <= '0;
							done_q    <= '0;
						end
					endcase
				end
				S_CMPL: begin
					if (st_rdata == JST_WAIT || st_rdata == JST_RUN) begin
						pending_q <= pending_q - CNT_W'(1);
					end
					done_q[IDX_W'(tgt_q)] <= succ_q;
					state_q               <= S_EMIT;
				end
				S_SCAN: begin
					// Keep the first highest priority among eligible slots
					if (eligible && (!found_q || rd_prio > best_prio_q)) begin
						found_q     <= 1'b1;
						best_idx_q  <= ptr_q;
						best_prio_q <= rd_prio;
					end
					ptr_q <= ptr_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (found_q) begin
						res_idx_q <= best_idx_q;
					end else begin
						res_status_q <= STATUS_NO_READY;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			status        <= res_status_q;
			result_index  <= IDX_OUT_W'(res_idx_q);
			pending_count <= CNT_OUT_W'(pending_q);
		end
	end

endmodule
